/* src/lsystem_rhythm_divider_unit_macros.svh */
// ---------------------------------------------------------------------------
// L-system rhythm divider assertion macros
// Concurrent checks clocked on clk and held off while rst is high.
// ---------------------------------------------------------------------------
`ifndef LSYSTEM_RHYTHM_DIVIDER_UNIT_MACROS_SVH
`define LSYSTEM_RHYTHM_DIVIDER_UNIT_MACROS_SVH

// same-cycle implication
`define LRD_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/lrd_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lrd_pkg
// Shared types, constants and helpers of the L-system rhythm divider.
// ---------------------------------------------------------------------------
package lrd_pkg;

  // defaults of the top-level parameters
  localparam int WORD_LENGTH_DEF = 8;
  localparam int DEPTH_LIMIT_DEF = 4;
  localparam int RULE_LENGTH_DEF = 4;

  // fixed field widths
  localparam int SAMPLE_W   = 15;
  localparam int VAL_W      = 5;
  localparam int RULE_W     = 11;
  localparam int CNT_W      = 4;
  localparam int DEPTH_W    = 3;
  localparam int KW         = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // symbol codes
  localparam logic [1:0] SYM_A = 2'd0;

  // schmitt trigger thresholds in millivolts
  localparam logic signed [SAMPLE_W-1:0] RISE_MV = 15'sd2000;
  localparam logic signed [SAMPLE_W-1:0] FALL_MV = 15'sd100;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VALUE_A = 3'd0,
    REG_VALUE_B = 3'd1,
    REG_VALUE_C = 3'd2,
    REG_VALUE_D = 3'd3,
    REG_RULE_A  = 3'd4,
    REG_RULE_B  = 3'd5,
    REG_RULE_C  = 3'd6,
    REG_RULE_D  = 3'd7
  } cfg_reg_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_REWRITE,
    S_LOAD,
    S_DONE
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic evaluate;
    logic rw_step;
    logic load;
    logic finish;
  } lrd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rose;
    logic dc_zero;
    logic wrap;
    logic depth_below;
    logic rw_done;
    logic out_free;
  } lrd_status_t;

  // divide count of a value register, clamped to 1..16
  function automatic logic [VAL_W-1:0] sym_value(input logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] r;
    if (v == '0) r = 5'd1;
    else if (v > 5'd16) r = 5'd16;
    else r = v;
    return r;
  endfunction

endpackage

/* src/lrd_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lrd_ctrl
// Sequencer of the divider: accept, evaluate, rewrite, load and deliver.
// ---------------------------------------------------------------------------
module lrd_ctrl
  import lrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  lrd_status_t status,
  output lrd_cmd_t    cmd
);

  ctrl_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (sample_valid) state_next = S_STEP;
      end
      S_STEP: begin
        if (status.rose && status.dc_zero) begin
          if (status.wrap && status.depth_below) state_next = S_REWRITE;
          else state_next = S_LOAD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_REWRITE: begin
        if (status.rw_done) state_next = S_LOAD;
      end
      S_LOAD: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // commands and input handshake
  always_comb begin
    cmd          = '0;
    sample_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        sample_stall = 1'b0;
        cmd.capture  = sample_valid;
      end
      S_STEP:    cmd.evaluate = 1'b1;
      S_REWRITE: cmd.rw_step  = 1'b1;
      S_LOAD:    cmd.load     = 1'b1;
      S_DONE:    cmd.finish   = status.out_free;
      default: begin
        cmd          = '0;
        sample_stall = 1'b1;
      end
    endcase
  end

endmodule

/* src/lrd_dp.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lrd_dp
// Datapath: trigger, divide counter, double-banked word store, rewrite
// walker, configuration registers and the result register.
// ---------------------------------------------------------------------------
`include "lsystem_rhythm_divider_unit_macros.svh"

module lrd_dp
  import lrd_pkg::*;
#(
  parameter int WORD_LENGTH = WORD_LENGTH_DEF,
  parameter int DEPTH_LIMIT = DEPTH_LIMIT_DEF,
  parameter int RULE_LENGTH = RULE_LENGTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lrd_cmd_t                   cmd,
  output lrd_status_t                status,
  input  logic                       cfg_write,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [SAMPLE_W-1:0] gate_sample,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic signed [SAMPLE_W-1:0] gated_sample,
  output logic                       gate_open
);

  localparam int PW = $clog2(WORD_LENGTH);
  localparam int LW = $clog2(WORD_LENGTH + 1);
  localparam logic [LW-1:0]      WordMax  = LW'(WORD_LENGTH);
  localparam logic [DEPTH_W-1:0] DepthMax = DEPTH_W'(DEPTH_LIMIT);
  localparam logic [KW-1:0]      RuleMax  = KW'(RULE_LENGTH);

  logic [VAL_W-1:0]  value_reg [4];
  logic [RULE_W-1:0] rule_reg  [4];

  logic [1:0] word_mem [2][WORD_LENGTH];
  logic       sel;

  logic signed [SAMPLE_W-1:0] sample;
  logic              trig;
  logic              open_flag;
  logic [LW-1:0]     length;
  logic [PW-1:0]     position;
  logic [CNT_W-1:0]  dc;
  logic [VAL_W-1:0]  modulus;
  logic [DEPTH_W-1:0] depth;
  logic [LW-1:0]     rw_i;
  logic [LW-1:0]     rw_n;
  logic [KW-1:0]     rw_k;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < 4; j++) begin
        value_reg[j] <= VAL_W'(1);
        rule_reg[j]  <= '0;
      end
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_VALUE_A: value_reg[0] <= cfg_data[VAL_W-1:0];
        REG_VALUE_B: value_reg[1] <= cfg_data[VAL_W-1:0];
        REG_VALUE_C: value_reg[2] <= cfg_data[VAL_W-1:0];
        REG_VALUE_D: value_reg[3] <= cfg_data[VAL_W-1:0];
        REG_RULE_A:  rule_reg[0]  <= cfg_data[RULE_W-1:0];
        REG_RULE_B:  rule_reg[1]  <= cfg_data[RULE_W-1:0];
        REG_RULE_C:  rule_reg[2]  <= cfg_data[RULE_W-1:0];
        REG_RULE_D:  rule_reg[3]  <= cfg_data[RULE_W-1:0];
      endcase
    end
  end

  // trigger edge and position step
  logic [LW-1:0] pos_ext;
  logic [LW-1:0] pos_inc;
  logic          rose;
  logic          trig_next;
  logic          wrap;
  logic [PW-1:0] pos_next;

  assign pos_ext   = LW'(position);
  assign pos_inc   = pos_ext + LW'(1);
  assign rose      = !trig && (sample >= RISE_MV);
  assign trig_next = trig ? !(sample <= FALL_MV) : (sample >= RISE_MV);
  assign wrap      = (pos_inc == length);
  assign pos_next  = wrap ? '0 : pos_inc[PW-1:0];

  // divide counter step against the current modulus
  logic [VAL_W-1:0] dc_ext;
  logic [VAL_W-1:0] dc_inc;
  logic [CNT_W-1:0] dc_step;

  assign dc_ext  = VAL_W'(dc);
  assign dc_inc  = dc_ext + VAL_W'(1);
  assign dc_step = (dc_inc == modulus) ? '0 : dc_inc[CNT_W-1:0];

  // single read port of the current bank
  logic [PW-1:0] rd_addr;
  logic [1:0]    rd_sym;

  assign rd_addr = cmd.load ? position : rw_i[PW-1:0];
  assign rd_sym  = word_mem[sel][rd_addr];

  // rule decode for the symbol under the walker
  logic [RULE_W-1:0] rule;
  logic [KW-1:0]     len_raw;
  logic [KW-1:0]     len_r;
  logic [15:0]       rule_shift;
  logic [1:0]        sym_k;
  logic              rw_done;
  logic              emit;

  assign rule       = rule_reg[rd_sym];
  assign len_raw    = KW'(rule[10:8]);
  assign len_r      = (len_raw > RuleMax) ? RuleMax : len_raw;
  assign rule_shift = 16'(rule) >> {rw_k, 1'b0};
  assign sym_k      = rule_shift[1:0];
  assign rw_done    = (rw_i >= length) || (rw_n == WordMax);
  assign emit       = (rw_k < len_r);

  // loaded divide count of the new current symbol
  logic [VAL_W-1:0] load_mod;

  assign load_mod = sym_value(value_reg[rd_sym]);

  // word store, two banks: rewrite fills the idle bank
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < 2; b++) begin
        for (int j = 0; j < WORD_LENGTH; j++) begin
          word_mem[b][j] <= SYM_A;
        end
      end
    end else begin
      if (cmd.evaluate && rose && status.dc_zero && wrap && !status.depth_below) begin
        word_mem[sel][0] <= SYM_A;
      end
      if (cmd.rw_step && !rw_done && emit) begin
        word_mem[!sel][rw_n[PW-1:0]] <= sym_k;
      end
      if (cmd.rw_step && rw_done && (rw_n == '0)) begin
        word_mem[!sel][0] <= SYM_A;
      end
    end
  end

  // divider state
  always_ff @(posedge clk) begin
    if (rst) begin
      sel       <= 1'b0;
      trig      <= 1'b0;
      open_flag <= 1'b0;
      length    <= LW'(1);
      position  <= '0;
      dc        <= '0;
      modulus   <= VAL_W'(1);
      depth     <= '0;
      rw_i      <= '0;
      rw_n      <= '0;
      rw_k      <= '0;
    end else begin
      if (cmd.evaluate) begin
        trig <= trig_next;
        rw_i <= '0;
        rw_n <= '0;
        rw_k <= '0;
        if (rose) begin
          if (status.dc_zero) begin
            position <= pos_next;
            if (wrap && !status.depth_below) begin
              length <= LW'(1);
              depth  <= '0;
            end
          end else begin
            open_flag <= 1'b0;
            dc        <= dc_step;
          end
        end
      end
      if (cmd.rw_step) begin
        if (rw_done) begin
          length <= (rw_n == '0) ? LW'(1) : rw_n;
          sel    <= !sel;
          depth  <= depth + DEPTH_W'(1);
        end else if (emit) begin
          rw_n <= rw_n + LW'(1);
          rw_k <= rw_k + KW'(1);
        end else begin
          rw_i <= rw_i + LW'(1);
          rw_k <= '0;
        end
      end
      if (cmd.load) begin
        modulus   <= load_mod;
        open_flag <= 1'b1;
        dc        <= (load_mod == VAL_W'(1)) ? '0 : CNT_W'(1);
      end
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample <= gate_sample;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      gated_sample <= open_flag ? sample : '0;
      gate_open    <= open_flag;
    end
  end

  // status to the controller
  always_comb begin
    status.rose        = rose;
    status.dc_zero     = (dc == '0);
    status.wrap        = wrap;
    status.depth_below = (depth < DepthMax);
    status.rw_done     = rw_done;
    status.out_free    = !result_valid || !result_stall;
  end

  // checks
  logic len_ok;
  assign len_ok = (length != '0) && (length <= WordMax);

  `LRD_ASSERT(a_dc_below_mod, 1'b1, dc_ext < modulus, "divide count reached modulus")
  `LRD_ASSERT(a_pos_in_word, 1'b1, pos_ext < length, "position beyond word length")
  `LRD_ASSERT(a_len_range, 1'b1, len_ok, "word length out of range")
  `LRD_ASSERT(a_closed_zero, result_valid && !gate_open, gated_sample == '0, "closed gate leaks")
  `LRD_ASSERT_NEXT(a_finish_valid, cmd.finish, result_valid, "finished beat not presented")

endmodule

/* src/lsystem_rhythm_divider_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsystem_rhythm_divider_unit
// Clock divider steered by an L-system word: gate samples in, gated samples
// out, one result beat per input beat.
// ---------------------------------------------------------------------------
// channel   | handshake                    | payload
// sample    | sample_valid / sample_stall  | gate_sample
// result    | result_valid / result_stall  | gated_sample, gate_open
// config    | cfg_write                    | cfg_index, cfg_data
//
// A beat runs accept, evaluate, load when the gate opens, and deliver; on a
// word wrap below the depth limit the rewrite walker runs before load (one
// symbol read or one symbol write per cycle through the single word-store
// port). rst is synchronous; it restores the single-symbol word and clears
// all control state. A new sample is taken while the previous result beat
// still waits under result_stall; delivery holds only at the end of a beat.
// ---------------------------------------------------------------------------
module lsystem_rhythm_divider_unit
  import lrd_pkg::*;
#(
  parameter int WORD_LENGTH = WORD_LENGTH_DEF,
  parameter int DEPTH_LIMIT = DEPTH_LIMIT_DEF,
  parameter int RULE_LENGTH = RULE_LENGTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       sample_valid,
  output logic                       sample_stall,
  input  logic signed [SAMPLE_W-1:0] gate_sample,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic signed [SAMPLE_W-1:0] gated_sample,
  output logic                       gate_open
);

  lrd_cmd_t    cmd;
  lrd_status_t status;

  // sequencer
  lrd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // datapath
  lrd_dp #(
    .WORD_LENGTH (WORD_LENGTH),
    .DEPTH_LIMIT (DEPTH_LIMIT),
    .RULE_LENGTH (RULE_LENGTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .gate_sample  (gate_sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .gated_sample (gated_sample),
    .gate_open    (gate_open)
  );

endmodule

/* tb/sv/tb_lsystem_rhythm_divider_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_lsystem_rhythm_divider_unit
// Self-checking bench for the L-system rhythm divider. A short table of
// directed beats and register writes is walked first, then randomised phases
// with fresh divide counts and rewrite rules. Every accepted sample beat is
// run through a behavioural copy of the divider, and each result beat is
// compared with the oldest prediction. Both channels idle in random bursts.
// ---------------------------------------------------------------------------
module tb_lsystem_rhythm_divider_unit;
  import lrd_pkg::*;

  localparam int DRAIN_CYCLES    = 24;
  localparam int PHASES          = 8;
  localparam int BEATS_PER_PHASE = 225;
  localparam int PLAN_ROWS       = 26;

  // one result beat
  typedef struct {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       is_open;
  } gate_beat_t;

  // directed table row: either a sample beat or a register write
  typedef enum logic {ROW_BEAT, ROW_SETTING} row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    cfg_reg_t                   idx;
    logic [CFG_DATA_W-1:0]      data;
    logic signed [SAMPLE_W-1:0] smp;
    bit                         typed;
    logic signed [SAMPLE_W-1:0] exp_smp;
    logic                       exp_open;
  } plan_row_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_write;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;
  logic                       sample_valid;
  logic                       sample_stall;
  logic signed [SAMPLE_W-1:0] gate_sample;
  logic                       result_valid;
  logic                       result_stall;
  logic signed [SAMPLE_W-1:0] gated_sample;
  logic                       gate_open;

  // idling controls
  bit send_idle;
  bit recv_idle;
  bit calm;
  int stall_left;

  int         mismatch_count;
  gate_beat_t gate_results_due [$];

  // divider copy: registers and state
  logic [VAL_W-1:0]  value_regs [4];
  logic [RULE_W-1:0] rule_regs [4];
  logic [1:0]        word_syms [WORD_LENGTH_DEF];
  int                word_len;
  int                word_pos;
  int                div_count;
  int                div_modulus;
  int                rw_depth;
  logic              gate_is_open;
  logic              schmitt_high;

  // reset state, then a few extreme registers and odd rules
  plan_row_t opening_plan [PLAN_ROWS] = '{
    '{ROW_BEAT, REG_VALUE_A, 11'd0, 15'sd0, 1'b1, 15'sd0, 1'b0},
    '{ROW_BEAT, REG_VALUE_A, 11'd0, 15'sd1999, 1'b1, 15'sd0, 1'b0},
    '{ROW_BEAT, REG_VALUE_A, 11'd0, 15'sd2000, 1'b1, 15'sd2000, 1'b1},
    '{ROW_BEAT, REG_VALUE_A, 11'd0, 15'sd16383, 1'b1, 15'sd16383, 1'b1},
    '{ROW_BEAT, REG_VALUE_A, 11'd0, 15'sd101, 1'b1, 15'sd101, 1'b1},
    '{ROW_BEAT, REG_VALUE_A, 11'd0, 15'sd100, 1'b1, 15'sd100, 1'b1},
    '{ROW_BEAT, REG_VALUE_A, 11'd0, 15'h4000, 1'b1, 15'h4000, 1'b1},
    '{ROW_BEAT, REG_VALUE_A, 11'd0, 15'sd12000, 1'b1, 15'sd12000, 1'b1},
    // rule length seven saturates, empty rule, length five, length one
    '{ROW_SETTING, REG_RULE_A, 11'h7E4, 15'sd0, 1'b0, 15'sd0, 1'b0},
    '{ROW_SETTING, REG_RULE_B, 11'h000, 15'sd0, 1'b0, 15'sd0, 1'b0},
    '{ROW_SETTING, REG_RULE_C, 11'h5FF, 15'sd0, 1'b0, 15'sd0, 1'b0},
    '{ROW_SETTING, REG_RULE_D, 11'h101, 15'sd0, 1'b0, 15'sd0, 1'b0},
    // zero reads as one, out-of-range reads as sixteen, upper data bits dropped
    '{ROW_SETTING, REG_VALUE_A, 11'd0, 15'sd0, 1'b0, 15'sd0, 1'b0},
    '{ROW_SETTING, REG_VALUE_B, 11'd31, 15'sd0, 1'b0, 15'sd0, 1'b0},
    '{ROW_SETTING, REG_VALUE_C, 11'd17, 15'sd0, 1'b0, 15'sd0, 1'b0},
    '{ROW_SETTING, REG_VALUE_D, 11'h7E3, 15'sd0, 1'b0, 15'sd0, 1'b0},
    '{ROW_BEAT, REG_VALUE_A, 11'd0, -15'sd12000, 1'b0, 15'sd0, 1'b0},
    '{ROW_BEAT, REG_VALUE_A, 11'd0, 15'sd2000, 1'b0, 15'sd0, 1'b0},
    '{ROW_BEAT, REG_VALUE_A, 11'd0, 15'sd0, 1'b0, 15'sd0, 1'b0},
    '{ROW_BEAT, REG_VALUE_A, 11'd0, 15'sd3000, 1'b0, 15'sd0, 1'b0},
    '{ROW_BEAT, REG_VALUE_A, 11'd0, 15'sd50, 1'b0, 15'sd0, 1'b0},
    '{ROW_BEAT, REG_VALUE_A, 11'd0, 15'sd16383, 1'b0, 15'sd0, 1'b0},
    '{ROW_BEAT, REG_VALUE_A, 11'd0, -15'sd1, 1'b0, 15'sd0, 1'b0},
    '{ROW_BEAT, REG_VALUE_A, 11'd0, 15'sd2000, 1'b0, 15'sd0, 1'b0},
    '{ROW_BEAT, REG_VALUE_A, 11'd0, 15'sd100, 1'b0, 15'sd0, 1'b0},
    '{ROW_BEAT, REG_VALUE_A, 11'd0, 15'sd2500, 1'b0, 15'sd0, 1'b0}
  };

  lsystem_rhythm_divider_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .gate_sample  (gate_sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .gated_sample (gated_sample),
    .gate_open    (gate_open)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // divide count of a symbol, clamped to 1..16
  function automatic int divisor_of(input logic [1:0] sym);
    int v;
    v = int'(value_regs[sym]);
    if (v == 0) v = 1;
    else if (v > 16) v = 16;
    return v;
  endfunction

  // one sample through the trigger, divider and word rewrite
  task automatic advance_divider(input logic signed [SAMPLE_W-1:0] smp,
                                 output gate_beat_t beat);
    logic              rose;
    logic [1:0]        fresh [WORD_LENGTH_DEF];
    logic [RULE_W-1:0] rule;
    int                n;
    int                rlen;
    rose = 1'b0;
    if (schmitt_high) begin
      if (smp <= FALL_MV) schmitt_high = 1'b0;
    end else if (smp >= RISE_MV) begin
      schmitt_high = 1'b1;
      rose = 1'b1;
    end
    if (rose) begin
      if (div_count == 0) begin
        word_pos = (word_pos + 1) % word_len;
        if (word_pos == 0) begin
          if (rw_depth < DEPTH_LIMIT_DEF) begin
            // rewrite every symbol, truncated to the word size
            n = 0;
            for (int i = 0; i < word_len && n < WORD_LENGTH_DEF; i++) begin
              rule = rule_regs[word_syms[i]];
              rlen = int'(rule[10:8]);
              if (rlen > RULE_LENGTH_DEF) rlen = RULE_LENGTH_DEF;
              for (int k = 0; k < rlen && n < WORD_LENGTH_DEF; k++) begin
                fresh[n] = rule[2*k +: 2];
                n++;
              end
            end
            // nothing produced: fall back to a single a
            if (n == 0) begin
              fresh[0] = SYM_A;
              n = 1;
            end
            for (int i = 0; i < n; i++) word_syms[i] = fresh[i];
            word_len = n;
            rw_depth++;
          end else begin
            rw_depth = 0;
            word_syms[0] = SYM_A;
            word_len = 1;
          end
        end
        div_modulus = divisor_of(word_syms[word_pos]);
        gate_is_open = 1'b1;
      end else begin
        gate_is_open = 1'b0;
      end
      div_count = (div_count + 1) % div_modulus;
    end
    beat.smp = gate_is_open ? smp : '0;
    beat.is_open = gate_is_open;
  endtask

  // one sample beat, optionally preceded by an idle burst
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input bit typed,
                             input logic signed [SAMPLE_W-1:0] exp_smp,
                             input logic exp_open);
    gate_beat_t due;
    int         gap;
    @(negedge clk);
    if (send_idle && $urandom_range(0, 7) == 0) begin
      sample_valid = 1'b0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(negedge clk);
    end
    sample_valid = 1'b1;
    gate_sample = smp;
    do @(posedge clk); while (sample_stall);
    advance_divider(smp, due);
    if (typed) begin
      due.smp = exp_smp;
      due.is_open = exp_open;
    end
    gate_results_due = {gate_results_due, due};
  endtask

  // register write once the block has drained
  task automatic write_setting(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    sample_valid = 1'b0;
    while (gate_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    if (idx <= REG_VALUE_D) value_regs[idx[1:0]] = data[VAL_W-1:0];
    else rule_regs[idx[1:0]] = data;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // result side back-pressure in bursts
  initial begin
    result_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        result_stall = 1'b1;
      end else if (recv_idle && !calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        result_stall = 1'b1;
      end else begin
        result_stall = 1'b0;
      end
    end
  end

  // compare each accepted result beat with the oldest prediction
  always @(posedge clk) begin : result_check
    gate_beat_t due;
    if (!rst && result_valid && !result_stall) begin
      if (gate_results_due.size() == 0) begin
        $error("unexpected result beat: gated_sample %0d gate_open %0b",
               gated_sample, gate_open);
        mismatch_count++;
      end else begin
        due = gate_results_due.pop_front();
        if (gated_sample !== due.smp) begin
          $error("gated_sample: expected %0d, actual %0d", due.smp, gated_sample);
          mismatch_count++;
        end
        if (gate_open !== due.is_open) begin
          $error("gate_open: expected %0b, actual %0b", due.is_open, gate_open);
          mismatch_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int                         r;
    int                         rlen;
    logic [CFG_DATA_W-1:0]      data;
    logic signed [SAMPLE_W-1:0] smp;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_VALUE_A;
    cfg_data = '0;
    sample_valid = 1'b0;
    gate_sample = '0;
    send_idle = 1'b0;
    recv_idle = 1'b0;
    calm = 1'b0;
    mismatch_count = 0;

    // divider copy after reset
    for (int i = 0; i < 4; i++) begin
      value_regs[i] = 5'd1;
      rule_regs[i] = '0;
    end
    foreach (word_syms[i]) word_syms[i] = SYM_A;
    word_len = 1;
    word_pos = 0;
    div_count = 0;
    div_modulus = divisor_of(SYM_A);
    rw_depth = 0;
    gate_is_open = 1'b0;
    schmitt_high = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    send_idle = 1'b1;
    recv_idle = 1'b1;
    foreach (opening_plan[i]) begin
      if (opening_plan[i].kind == ROW_SETTING) begin
        write_setting(opening_plan[i].idx, opening_plan[i].data);
      end else begin
        send_sample(opening_plan[i].smp, opening_plan[i].typed,
                    opening_plan[i].exp_smp, opening_plan[i].exp_open);
      end
    end

    // random phases, each with its own register set
    for (int p = 0; p < PHASES; p++) begin
      calm = (p == PHASES - 1);
      send_idle = !calm && ($urandom_range(0, 3) != 0);
      recv_idle = !calm && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 8; i++) begin
        if (i < 4) begin
          case (p)
            0: data = 11'd0;
            1: data = 11'd31;
            2: data = 11'd16;
            default: begin
              r = $urandom_range(0, 4);
              if (r == 0) data = 11'd0;
              else if (r == 1) data = 11'($urandom_range(17, 31));
              else if (r == 2) data = 11'($urandom_range(0, 2047));
              else data = 11'($urandom_range(1, 4));
            end
          endcase
        end else if (p == 3) begin
          data = 11'd0;
        end else begin
          // mostly legal lengths, some empty, some oversized
          r = $urandom_range(0, 9);
          if (r == 0) rlen = 0;
          else if (r < 3) rlen = $urandom_range(5, 7);
          else rlen = $urandom_range(1, 4);
          data = {rlen[2:0], 8'($urandom_range(0, 255))};
        end
        write_setting(cfg_reg_t'(i), data);
      end
      for (int b = 0; b < BEATS_PER_PHASE; b++) begin
        // mostly alternate across the thresholds so that edges keep coming
        r = $urandom_range(0, 99);
        if (r < 70) begin
          if (schmitt_high) smp = 15'(int'($urandom_range(0, 16484)) - 16384);
          else smp = 15'($urandom_range(2000, 16383));
        end else if (r < 82) begin
          smp = 15'($urandom_range(101, 1999));
        end else if (r < 90) begin
          case ($urandom_range(0, 7))
            0: smp = 15'h4000;
            1: smp = 15'sd16383;
            2: smp = 15'sd100;
            3: smp = 15'sd101;
            4: smp = 15'sd1999;
            5: smp = 15'sd2000;
            6: smp = 15'sd0;
            default: smp = -15'sd1;
          endcase
        end else begin
          smp = 15'($urandom_range(0, 32767));
        end
        send_sample(smp, 1'b0, '0, 1'b0);
      end
    end

    // drain and report
    @(negedge clk);
    sample_valid = 1'b0;
    while (gate_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hang guard
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

/* lsystem_rhythm_divider_unit.f */
+incdir+src
src/lrd_pkg.sv
src/lrd_ctrl.sv
src/lrd_dp.sv
src/lsystem_rhythm_divider_unit.sv
tb/sv/tb_lsystem_rhythm_divider_unit.sv
